/* sv/rcl_pkg.sv */
// ----------------------------------------------------------------------------
// rcl_pkg: shared types and constants for the radical composition lookup
// Character codes, item kinds, status codes, the search request and response
// bundles, and the compose step table that drives the sequencer.
// ----------------------------------------------------------------------------
package rcl_pkg;

  localparam int CHAR_W = 16;
  typedef logic [CHAR_W-1:0] char_t;

  // Sentinel part code: 'N' in the high byte, 'L' in the low byte
  localparam char_t NL_CODE = 16'h4E4C;

  typedef enum logic [1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_APPEND  = 2'd1,
    KIND_COMPOSE = 2'd2,
    KIND_DECOMP  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NOTFOUND = 2'd1,
    STAT_FULL     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_DONE
  } state_t;

  // Step operations of the compose sequencer
  typedef enum logic [3:0] {
    OP_EQVA,   // a  = equivalent of ca
    OP_EQVB,   // b  = equivalent of cb
    OP_SPA,    // a1, a2 = parts of a
    OP_SPB,    // b1, b2 = parts of b
    OP_SP1,    // a11, a12 = parts of a1
    OP_SP2,    // a21, a22 = parts of a2
    OP_DEC,    // decompose item
    OP_PAIR,   // look up x + y
    OP_L2R,    // (x + y) + z
    OP_R2L,    // x + (y + z)
    OP_TAKEV   // take operand x directly
  } op_t;

  // Operand selectors; S_ONE reads as a nonzero constant
  typedef enum logic [3:0] {
    S_ONE, S_CA, S_CB, S_A, S_B, S_A1, S_A2, S_B1, S_B2,
    S_A11, S_A12, S_A21, S_A22
  } sel_t;

  typedef struct packed {
    char_t ca;
    char_t cb;
    char_t a;
    char_t b;
    char_t a1;
    char_t a2;
    char_t b1;
    char_t b2;
    char_t a11;
    char_t a12;
    char_t a21;
    char_t a22;
  } vals_t;

  typedef struct packed {
    op_t  op;
    logic ext;
    sel_t x;
    sel_t y;
    sel_t z;
    sel_t g0;
    sel_t g1;
    sel_t g2;
    logic eq_en;
    sel_t e0;
    sel_t e1;
    sel_t e2;
  } step_t;

  typedef struct packed {
    char_t part1;
    char_t part2;
    char_t whole;
  } entry_t;

  typedef struct packed {
    logic  start;
    logic  is_pair;
    char_t kx;
    char_t ky;
  } srch_req_t;

  typedef struct packed {
    logic   done;
    logic   found;
    entry_t ent;
  } srch_rsp_t;

  localparam int PC_W = 6;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_LOOP = 6'd4;
  localparam pc_t PC_LAST = 6'd41;
  localparam pc_t PC_DEC  = 6'd42;

  function automatic char_t pick(vals_t v, sel_t s);
    char_t r;
    case (s)
      S_CA:    r = v.ca;
      S_CB:    r = v.cb;
      S_A:     r = v.a;
      S_B:     r = v.b;
      S_A1:    r = v.a1;
      S_A2:    r = v.a2;
      S_B1:    r = v.b1;
      S_B2:    r = v.b2;
      S_A11:   r = v.a11;
      S_A12:   r = v.a12;
      S_A21:   r = v.a21;
      S_A22:   r = v.a22;
      default: r = char_t'(1);
    endcase
    return r;
  endfunction

  function automatic step_t mk(op_t op, logic ext, sel_t x, sel_t y, sel_t z,
                               sel_t g0, sel_t g1, sel_t g2,
                               logic eq_en, sel_t e0, sel_t e1, sel_t e2);
    step_t s;
    s.op    = op;
    s.ext   = ext;
    s.x     = x;
    s.y     = y;
    s.z     = z;
    s.g0    = g0;
    s.g1    = g1;
    s.g2    = g2;
    s.eq_en = eq_en;
    s.e0    = e0;
    s.e1    = e1;
    s.e2    = e2;
    return s;
  endfunction

  // Compose order of tries; steps PC_LOOP..PC_LAST run once per operand order
  function automatic step_t rcl_step(pc_t pc);
    step_t s;
    case (pc)
      6'd0:  s = mk(OP_EQVA, 0, S_CA, S_ONE, S_ONE, S_ONE, S_ONE, S_ONE, 0, S_ONE, S_ONE, S_ONE);
      6'd1:  s = mk(OP_EQVB, 0, S_CB, S_ONE, S_ONE, S_ONE, S_ONE, S_ONE, 0, S_ONE, S_ONE, S_ONE);
      6'd2:  s = mk(OP_SPA, 0, S_A, S_ONE, S_ONE, S_ONE, S_ONE, S_ONE, 0, S_ONE, S_ONE, S_ONE);
      6'd3:  s = mk(OP_SPB, 0, S_B, S_ONE, S_ONE, S_ONE, S_ONE, S_ONE, 0, S_ONE, S_ONE, S_ONE);
      // direct addition, addition of equivalents
      6'd4:  s = mk(OP_PAIR, 0, S_CA, S_CB, S_ONE, S_ONE, S_ONE, S_ONE, 0, S_ONE, S_ONE, S_ONE);
      6'd5:  s = mk(OP_PAIR, 0, S_A, S_B, S_ONE, S_ONE, S_ONE, S_ONE, 0, S_ONE, S_ONE, S_ONE);
      6'd6:  s = mk(OP_L2R, 1, S_A1, S_B, S_A2, S_A1, S_A2, S_ONE, 0, S_ONE, S_ONE, S_ONE);
      6'd7:  s = mk(OP_R2L, 1, S_A1, S_A2, S_B, S_A1, S_A2, S_ONE, 0, S_ONE, S_ONE, S_ONE);
      6'd8:  s = mk(OP_L2R, 1, S_A, S_B1, S_B2, S_B1, S_B2, S_ONE, 0, S_ONE, S_ONE, S_ONE);
      6'd9:  s = mk(OP_R2L, 1, S_B1, S_A, S_B2, S_B1, S_B2, S_ONE, 0, S_ONE, S_ONE, S_ONE);
      // subtraction of the whole second operand
      6'd10: s = mk(OP_TAKEV, 0, S_A1, S_ONE, S_ONE, S_A1, S_A2, S_ONE, 1, S_A2, S_B, S_B);
      6'd11: s = mk(OP_TAKEV, 0, S_A2, S_ONE, S_ONE, S_A1, S_A2, S_ONE, 1, S_A1, S_B, S_B);
      6'd12: s = mk(OP_SP1, 1, S_A1, S_ONE, S_ONE, S_A1, S_ONE, S_ONE, 0, S_ONE, S_ONE, S_ONE);
      6'd13: s = mk(OP_SP2, 1, S_A2, S_ONE, S_ONE, S_A2, S_ONE, S_ONE, 0, S_ONE, S_ONE, S_ONE);
      6'd14: s = mk(OP_PAIR, 1, S_A11, S_A2, S_ONE, S_A2, S_A11, S_A12, 1, S_A12, S_B, S_B);
      6'd15: s = mk(OP_PAIR, 1, S_A12, S_A2, S_ONE, S_A2, S_A11, S_A12, 1, S_A11, S_B, S_B);
      6'd16: s = mk(OP_PAIR, 1, S_A1, S_A21, S_ONE, S_A1, S_A21, S_A22, 1, S_A22, S_B, S_B);
      6'd17: s = mk(OP_PAIR, 1, S_A1, S_A22, S_ONE, S_A1, S_A21, S_A22, 1, S_A21, S_B, S_B);
      // addition of parts
      6'd18: s = mk(OP_PAIR, 0, S_A, S_B1, S_ONE, S_A, S_B1, S_ONE, 0, S_ONE, S_ONE, S_ONE);
      6'd19: s = mk(OP_PAIR, 0, S_A, S_B2, S_ONE, S_A, S_B2, S_ONE, 0, S_ONE, S_ONE, S_ONE);
      6'd20: s = mk(OP_PAIR, 0, S_A1, S_B, S_ONE, S_A1, S_B, S_ONE, 0, S_ONE, S_ONE, S_ONE);
      6'd21: s = mk(OP_PAIR, 0, S_A2, S_B, S_ONE, S_A2, S_B, S_ONE, 0, S_ONE, S_ONE, S_ONE);
      6'd22: s = mk(OP_L2R, 1, S_A1, S_B1, S_A2, S_A1, S_A2, S_B1, 0, S_ONE, S_ONE, S_ONE);
      6'd23: s = mk(OP_R2L, 1, S_A1, S_A2, S_B1, S_A1, S_A2, S_B1, 0, S_ONE, S_ONE, S_ONE);
      6'd24: s = mk(OP_L2R, 1, S_A1, S_B2, S_A2, S_A1, S_A2, S_B2, 0, S_ONE, S_ONE, S_ONE);
      6'd25: s = mk(OP_R2L, 1, S_A1, S_A2, S_B2, S_A1, S_A2, S_B2, 0, S_ONE, S_ONE, S_ONE);
      6'd26: s = mk(OP_L2R, 1, S_A1, S_B1, S_B2, S_A1, S_B1, S_B2, 0, S_ONE, S_ONE, S_ONE);
      6'd27: s = mk(OP_R2L, 1, S_B1, S_A1, S_B2, S_A1, S_B1, S_B2, 0, S_ONE, S_ONE, S_ONE);
      6'd28: s = mk(OP_L2R, 1, S_A2, S_B1, S_B2, S_A2, S_B1, S_B2, 0, S_ONE, S_ONE, S_ONE);
      6'd29: s = mk(OP_R2L, 1, S_B1, S_A2, S_B2, S_A2, S_B1, S_B2, 0, S_ONE, S_ONE, S_ONE);
      6'd30: s = mk(OP_PAIR, 0, S_A1, S_B1, S_ONE, S_A1, S_B1, S_ONE, 0, S_ONE, S_ONE, S_ONE);
      6'd31: s = mk(OP_PAIR, 0, S_A1, S_B2, S_ONE, S_A1, S_B2, S_ONE, 0, S_ONE, S_ONE, S_ONE);
      6'd32: s = mk(OP_PAIR, 0, S_A2, S_B1, S_ONE, S_A2, S_B1, S_ONE, 0, S_ONE, S_ONE, S_ONE);
      6'd33: s = mk(OP_PAIR, 0, S_A2, S_B2, S_ONE, S_A2, S_B2, S_ONE, 0, S_ONE, S_ONE, S_ONE);
      // subtraction by parts
      6'd34: s = mk(OP_TAKEV, 0, S_A1, S_ONE, S_ONE, S_A2, S_B1, S_ONE, 1, S_A2, S_B1, S_B1);
      6'd35: s = mk(OP_TAKEV, 0, S_A1, S_ONE, S_ONE, S_A2, S_B2, S_ONE, 1, S_A2, S_B2, S_B2);
      6'd36: s = mk(OP_TAKEV, 0, S_A2, S_ONE, S_ONE, S_A1, S_B1, S_ONE, 1, S_A1, S_B1, S_B1);
      6'd37: s = mk(OP_TAKEV, 0, S_A2, S_ONE, S_ONE, S_A1, S_B2, S_ONE, 1, S_A1, S_B2, S_B2);
      6'd38: s = mk(OP_PAIR, 1, S_A11, S_A2, S_ONE, S_A2, S_A11, S_A12, 1, S_A12, S_B1, S_B2);
      6'd39: s = mk(OP_PAIR, 1, S_A12, S_A2, S_ONE, S_A2, S_A11, S_A12, 1, S_A11, S_B1, S_B2);
      6'd40: s = mk(OP_PAIR, 1, S_A1, S_A21, S_ONE, S_A1, S_A21, S_A22, 1, S_A22, S_B1, S_B2);
      6'd41: s = mk(OP_PAIR, 1, S_A1, S_A22, S_ONE, S_A1, S_A21, S_A22, 1, S_A21, S_B1, S_B2);
      default: s = mk(OP_DEC, 0, S_CA, S_ONE, S_ONE, S_ONE, S_ONE, S_ONE, 0, S_ONE, S_ONE, S_ONE);
    endcase
    return s;
  endfunction

endpackage

/* sv/rcl_search.sv */
// ----------------------------------------------------------------------------
// rcl_search: entry table and linear search unit
// Holds the entry memory and scans entries 0..count-1, one read per cycle,
// for the lowest entry matching a whole character or a pair of parts.
// ----------------------------------------------------------------------------
module rcl_search #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rcl_pkg::srch_req_t                 req,
  input  logic                               wr_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0]     wr_addr,
  input  rcl_pkg::entry_t                    wr_data,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]   count,
  output rcl_pkg::srch_rsp_t                 rsp
);
  import rcl_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH+1);

  entry_t         mem [TABLE_DEPTH];
  entry_t         rd_q;

  logic           busy_r, busy_nxt;
  logic [CW-1:0]  idx_r, idx_nxt;
  logic           vld_r, vld_nxt;
  logic           pair_r, pair_nxt;
  char_t          kx_r, kx_nxt;
  char_t          ky_r, ky_nxt;
  srch_rsp_t      rsp_r, rsp_nxt;

  logic           issue;
  logic           hit;

  // Write on append, read the entry under the scan pointer
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_q <= mem[idx_r[AW-1:0]];
    end
  end

  // Issue one read per cycle, compare the entry read on the cycle before
  always_comb begin
    issue = busy_r && (idx_r < count);
    hit   = vld_r && (pair_r ? (rd_q.part1 == kx_r && rd_q.part2 == ky_r)
                             : (rd_q.whole == kx_r));
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    vld_nxt  = vld_r;
    pair_nxt = pair_r;
    kx_nxt   = kx_r;
    ky_nxt   = ky_r;
    rsp_nxt  = rsp_r;
    rsp_nxt.done = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      vld_nxt  = 1'b0;
      pair_nxt = req.is_pair;
      kx_nxt   = req.kx;
      ky_nxt   = req.ky;
    end else if (busy_r) begin
      if (hit) begin
        busy_nxt      = 1'b0;
        vld_nxt       = 1'b0;
        rsp_nxt.done  = 1'b1;
        rsp_nxt.found = 1'b1;
        rsp_nxt.ent   = rd_q;
      end else if (!vld_r && !issue) begin
        busy_nxt      = 1'b0;
        rsp_nxt.done  = 1'b1;
        rsp_nxt.found = 1'b0;
      end else begin
        idx_nxt = idx_r + CW'(issue);
        vld_nxt = issue;
      end
    end
  end

  // Hold control in reset, keys and data need none
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      vld_r      <= 1'b0;
      idx_r      <= '0;
      rsp_r.done <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      vld_r      <= vld_nxt;
      idx_r      <= idx_nxt;
      rsp_r.done <= rsp_nxt.done;
    end
    pair_r      <= pair_nxt;
    kx_r        <= kx_nxt;
    ky_r        <= ky_nxt;
    rsp_r.found <= rsp_nxt.found;
    rsp_r.ent   <= rsp_nxt.ent;
  end

  assign rsp = rsp_r;

endmodule

/* sv/radical_composition_lookup.sv */
// ----------------------------------------------------------------------------
// radical_composition_lookup: character composition table and compose engine
// Clears, appends to and searches a table of whole = first + second entries,
// and composes two characters through a fixed order of table lookups.
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  in_      input      in_valid/in_stall   kind, char_first/second/whole
//  out_     output     out_valid/out_stall result_char, part_first/second, status
//  cfg_     input      cfg_wr_en           cfg_wr_data (algorithm mode)
//
//  Clear and append need no table scan; decompose takes one table scan.
//  Compose runs up to 92 scans of the single search unit (one entry
//  read per cycle). One item at a time: in_stall is high from transfer
//  until the result transfers. Synchronous reset empties the table
//  (count to zero) and sets the basic mode. A stalled result holds.
// ----------------------------------------------------------------------------
module radical_composition_lookup #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     in_kind,
  input  rcl_pkg::char_t in_char_first,
  input  rcl_pkg::char_t in_char_second,
  input  rcl_pkg::char_t in_char_whole,
  output logic           out_valid,
  input  logic           out_stall,
  output rcl_pkg::char_t out_result_char,
  output rcl_pkg::char_t out_part_first,
  output rcl_pkg::char_t out_part_second,
  output logic [1:0]     out_status,
  input  logic           cfg_wr_en,
  input  logic           cfg_wr_data
);
  import rcl_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH+1);

  state_t         state_r, state_nxt;
  pc_t            pc_r, pc_nxt;
  logic           iter_r, iter_nxt;
  logic           phase_r, phase_nxt;
  logic           mode_r, mode_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  vals_t          vals_r, vals_nxt;
  char_t          t_r, t_nxt;
  char_t          res_r, res_nxt;
  char_t          p1_r, p1_nxt;
  char_t          p2_r, p2_nxt;
  status_t        stat_r, stat_nxt;

  srch_req_t      req;
  srch_rsp_t      rsp;
  logic           wr_en;
  entry_t         wr_data;

  step_t          stp;
  char_t          xv, yv, zv, r_v, sw;
  logic           go, ext_skip, adv, fin;
  char_t          fin_v;
  logic           in_xfer;

  rcl_search #(.TABLE_DEPTH(TABLE_DEPTH)) u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (wr_data),
    .count   (count_r),
    .rsp     (rsp)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = (state_r == ST_DONE);
  assign out_result_char = res_r;
  assign out_part_first  = p1_r;
  assign out_part_second = p2_r;
  assign out_status      = stat_r;

  assign wr_data.part1 = in_char_first;
  assign wr_data.part2 = in_char_second;
  assign wr_data.whole = in_char_whole;

  // Sequencer: decode the current step, issue scans, fold in results
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    iter_nxt  = iter_r;
    phase_nxt = phase_r;
    mode_nxt  = cfg_wr_en ? cfg_wr_data : mode_r;
    count_nxt = count_r;
    vals_nxt  = vals_r;
    t_nxt     = t_r;
    res_nxt   = res_r;
    p1_nxt    = p1_r;
    p2_nxt    = p2_r;
    stat_nxt  = stat_r;
    wr_en     = 1'b0;
    req       = '0;
    adv       = 1'b0;
    fin       = 1'b0;
    fin_v     = '0;
    sw        = '0;

    stp      = rcl_step(pc_r);
    xv       = pick(vals_r, stp.x);
    yv       = pick(vals_r, stp.y);
    zv       = pick(vals_r, stp.z);
    r_v      = rsp.found ? rsp.ent.whole : '0;
    ext_skip = stp.ext && !mode_r;
    go       = !ext_skip
               && pick(vals_r, stp.g0) != '0
               && pick(vals_r, stp.g1) != '0
               && pick(vals_r, stp.g2) != '0
               && (!stp.eq_en
                   || pick(vals_r, stp.e0) == pick(vals_r, stp.e1)
                   || pick(vals_r, stp.e0) == pick(vals_r, stp.e2));

    // Scan keys for the current step and phase
    req.kx = xv;
    req.ky = yv;
    case (stp.op)
      OP_PAIR: req.is_pair = 1'b1;
      OP_L2R: begin
        req.is_pair = 1'b1;
        if (phase_r) begin
          req.kx = t_r;
          req.ky = zv;
        end
      end
      OP_R2L: begin
        req.is_pair = 1'b1;
        if (phase_r) begin
          req.ky = t_r;
        end else begin
          req.kx = yv;
          req.ky = zv;
        end
      end
      default: req.is_pair = 1'b0;
    endcase

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          res_nxt  = '0;
          p1_nxt   = '0;
          p2_nxt   = '0;
          stat_nxt = STAT_OK;
          pc_nxt   = '0;
          iter_nxt = 1'b0;
          phase_nxt = 1'b0;
          vals_nxt.ca = in_char_first;
          vals_nxt.cb = in_char_second;
          case (kind_t'(in_kind))
            KIND_CLEAR: begin
              count_nxt = '0;
              state_nxt = ST_DONE;
            end
            KIND_APPEND: begin
              if (count_r == CW'(TABLE_DEPTH)) begin
                stat_nxt = STAT_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + 1'b1;
              end
              state_nxt = ST_DONE;
            end
            KIND_COMPOSE: state_nxt = ST_RUN;
            default: begin
              pc_nxt    = PC_DEC;
              state_nxt = ST_RUN;
            end
          endcase
        end
      end

      ST_RUN: begin
        case (stp.op)
          OP_TAKEV: begin
            if (go && xv != vals_r.ca && xv != vals_r.cb) begin
              fin   = 1'b1;
              fin_v = xv;
            end else begin
              adv = 1'b1;
            end
          end
          OP_SP1, OP_SP2: begin
            if (ext_skip) begin
              adv = 1'b1;
            end else if (!go) begin
              if (stp.op == OP_SP1) begin
                vals_nxt.a11 = '0;
                vals_nxt.a12 = '0;
              end else begin
                vals_nxt.a21 = '0;
                vals_nxt.a22 = '0;
              end
              adv = 1'b1;
            end else begin
              req.start = 1'b1;
              state_nxt = ST_WAIT;
            end
          end
          default: begin
            if (go) begin
              req.start = 1'b1;
              state_nxt = ST_WAIT;
            end else begin
              adv = 1'b1;
            end
          end
        endcase
      end

      ST_WAIT: begin
        if (rsp.done) begin
          case (stp.op)
            OP_EQVA: begin
              vals_nxt.a = (rsp.found && rsp.ent.part1 == NL_CODE) ? rsp.ent.part2
                                                                    : vals_r.ca;
              adv = 1'b1;
            end
            OP_EQVB: begin
              vals_nxt.b = (rsp.found && rsp.ent.part1 == NL_CODE) ? rsp.ent.part2
                                                                    : vals_r.cb;
              adv = 1'b1;
            end
            OP_SPA: begin
              vals_nxt.a1 = (rsp.found && rsp.ent.part1 != NL_CODE) ? rsp.ent.part1 : '0;
              vals_nxt.a2 = (rsp.found && rsp.ent.part2 != NL_CODE) ? rsp.ent.part2 : '0;
              adv = 1'b1;
            end
            OP_SPB: begin
              vals_nxt.b1 = (rsp.found && rsp.ent.part1 != NL_CODE) ? rsp.ent.part1 : '0;
              vals_nxt.b2 = (rsp.found && rsp.ent.part2 != NL_CODE) ? rsp.ent.part2 : '0;
              adv = 1'b1;
            end
            OP_SP1: begin
              vals_nxt.a11 = (rsp.found && rsp.ent.part1 != NL_CODE) ? rsp.ent.part1 : '0;
              vals_nxt.a12 = (rsp.found && rsp.ent.part2 != NL_CODE) ? rsp.ent.part2 : '0;
              adv = 1'b1;
            end
            OP_SP2: begin
              vals_nxt.a21 = (rsp.found && rsp.ent.part1 != NL_CODE) ? rsp.ent.part1 : '0;
              vals_nxt.a22 = (rsp.found && rsp.ent.part2 != NL_CODE) ? rsp.ent.part2 : '0;
              adv = 1'b1;
            end
            OP_DEC: begin
              p1_nxt    = rsp.found ? rsp.ent.part1 : NL_CODE;
              p2_nxt    = rsp.found ? rsp.ent.part2 : NL_CODE;
              stat_nxt  = rsp.found ? STAT_OK : STAT_NOTFOUND;
              state_nxt = ST_DONE;
            end
            OP_L2R, OP_R2L: begin
              if (!phase_r) begin
                if (r_v == '0) begin
                  adv = 1'b1;
                end else begin
                  t_nxt     = r_v;
                  phase_nxt = 1'b1;
                  state_nxt = ST_RUN;
                end
              end else if (r_v != '0 && r_v != vals_r.ca && r_v != vals_r.cb) begin
                fin   = 1'b1;
                fin_v = r_v;
              end else begin
                adv = 1'b1;
              end
            end
            default: begin
              if (r_v != '0 && r_v != vals_r.ca && r_v != vals_r.cb) begin
                fin   = 1'b1;
                fin_v = r_v;
              end else begin
                adv = 1'b1;
              end
            end
          endcase
        end
      end

      ST_DONE: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // Finish with an answer, or advance to the next try
    if (fin) begin
      res_nxt   = fin_v;
      stat_nxt  = (fin_v != '0) ? STAT_OK : STAT_NOTFOUND;
      phase_nxt = 1'b0;
      state_nxt = ST_DONE;
    end else if (adv) begin
      phase_nxt = 1'b0;
      if (pc_r == PC_LAST) begin
        if (!iter_r) begin
          // swap operand order and rerun the tries
          sw = vals_nxt.ca; vals_nxt.ca = vals_nxt.cb; vals_nxt.cb = sw;
          sw = vals_nxt.a;  vals_nxt.a  = vals_nxt.b;  vals_nxt.b  = sw;
          sw = vals_nxt.a1; vals_nxt.a1 = vals_nxt.b1; vals_nxt.b1 = sw;
          sw = vals_nxt.a2; vals_nxt.a2 = vals_nxt.b2; vals_nxt.b2 = sw;
          iter_nxt  = 1'b1;
          pc_nxt    = PC_LOOP;
          state_nxt = ST_RUN;
        end else begin
          res_nxt   = '0;
          stat_nxt  = STAT_NOTFOUND;
          state_nxt = ST_DONE;
        end
      end else begin
        pc_nxt    = pc_r + 1'b1;
        state_nxt = ST_RUN;
      end
    end
  end

  // Hold control in reset, operands and results need none
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r    <= '0;
      iter_r  <= 1'b0;
      phase_r <= 1'b0;
      mode_r  <= 1'b0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      iter_r  <= iter_nxt;
      phase_r <= phase_nxt;
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
    end
    vals_r <= vals_nxt;
    t_r    <= t_nxt;
    res_r  <= res_nxt;
    p1_r   <= p1_nxt;
    p2_r   <= p2_nxt;
    stat_r <= stat_nxt;
  end

endmodule

/* sv/rcl_checker.sv */
// ----------------------------------------------------------------------------
// rcl_assertions: port-level checks for the radical composition lookup
// Watches the item and result channels and flags ordering and coding slips.
// ----------------------------------------------------------------------------
module rcl_assertions (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input rcl_pkg::char_t out_result_char,
  input rcl_pkg::char_t out_part_first,
  input rcl_pkg::char_t out_part_second,
  input logic [1:0]     out_status
);
  import rcl_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_char)
      && $stable(out_status))
    else $error("stalled result changed");

  // Take no item after a transfer until its result is gone
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item taken while busy");

  // Take no item while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("item taken while result pending");

  // Status never uses the spare code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STAT_OK || out_status == STAT_NOTFOUND
                   || out_status == STAT_FULL))
    else $error("bad status code");

  // Full table reports no characters
  a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_FULL |-> out_result_char == '0
      && out_part_first == '0 && out_part_second == '0)
    else $error("full status with data");

endmodule

bind radical_composition_lookup rcl_assertions u_rcl_assertions (.*);
